// File: rtl/vn2d_pkg.sv
package vn2d_pkg;

    localparam logic [1:0] CFG_FREQUENCY = 2'd0;
    localparam logic [1:0] CFG_OCTAVES   = 2'd1;
    localparam logic [1:0] CFG_SEED      = 2'd2;

    localparam logic [15:0] FREQUENCY_RESET = 16'd256;
    localparam logic [3:0]  OCTAVES_RESET   = 4'd4;
    localparam logic [7:0]  SEED_RESET      = 8'd254;

    localparam logic [7:0] PERM [256] = '{
        8'd51, 8'd152, 8'd157, 8'd231, 8'd235, 8'd201, 8'd241, 8'd242,
        8'd116, 8'd200, 8'd78, 8'd83, 8'd248, 8'd221, 8'd71, 8'd0,
        8'd181, 8'd186, 8'd150, 8'd31, 8'd143, 8'd61, 8'd104, 8'd219,
        8'd107, 8'd247, 8'd215, 8'd179, 8'd188, 8'd173, 8'd183, 8'd160,
        8'd243, 8'd35, 8'd155, 8'd154, 8'd67, 8'd54, 8'd169, 8'd177,
        8'd170, 8'd58, 8'd251, 8'd232, 8'd38, 8'd37, 8'd120, 8'd224,
        8'd191, 8'd230, 8'd145, 8'd103, 8'd73, 8'd218, 8'd2, 8'd167,
        8'd227, 8'd36, 8'd147, 8'd174, 8'd87, 8'd79, 8'd29, 8'd135,
        8'd50, 8'd193, 8'd86, 8'd182, 8'd12, 8'd184, 8'd137, 8'd100,
        8'd6, 8'd110, 8'd156, 8'd127, 8'd96, 8'd30, 8'd244, 8'd90,
        8'd140, 8'd252, 8'd69, 8'd151, 8'd208, 8'd212, 8'd21, 8'd93,
        8'd164, 8'd74, 8'd168, 8'd125, 8'd144, 8'd238, 8'd112, 8'd176,
        8'd60, 8'd222, 8'd45, 8'd41, 8'd214, 8'd199, 8'd209, 8'd34,
        8'd53, 8'd178, 8'd72, 8'd126, 8'd131, 8'd85, 8'd98, 8'd239,
        8'd46, 8'd24, 8'd17, 8'd197, 8'd115, 8'd20, 8'd249, 8'd205,
        8'd129, 8'd185, 8'd187, 8'd210, 8'd119, 8'd237, 8'd172, 8'd32,
        8'd44, 8'd105, 8'd109, 8'd27, 8'd180, 8'd236, 8'd42, 8'd7,
        8'd5, 8'd149, 8'd25, 8'd82, 8'd33, 8'd26, 8'd111, 8'd62,
        8'd130, 8'd228, 8'd77, 8'd97, 8'd66, 8'd217, 8'd153, 8'd146,
        8'd245, 8'd4, 8'd114, 8'd138, 8'd158, 8'd11, 8'd196, 8'd52,
        8'd171, 8'd39, 8'd211, 8'd113, 8'd133, 8'd159, 8'd204, 8'd128,
        8'd23, 8'd233, 8'd229, 8'd134, 8'd99, 8'd195, 8'd190, 8'd68,
        8'd16, 8'd220, 8'd56, 8'd63, 8'd223, 8'd162, 8'd43, 8'd57,
        8'd234, 8'd65, 8'd225, 8'd49, 8'd250, 8'd166, 8'd1, 8'd206,
        8'd226, 8'd165, 8'd121, 8'd124, 8'd84, 8'd253, 8'd81, 8'd40,
        8'd47, 8'd9, 8'd88, 8'd139, 8'd80, 8'd8, 8'd28, 8'd64,
        8'd95, 8'd192, 8'd70, 8'd207, 8'd202, 8'd136, 8'd55, 8'd216,
        8'd189, 8'd13, 8'd75, 8'd15, 8'd102, 8'd161, 8'd148, 8'd142,
        8'd117, 8'd141, 8'd18, 8'd76, 8'd254, 8'd19, 8'd14, 8'd89,
        8'd91, 8'd3, 8'd101, 8'd163, 8'd213, 8'd92, 8'd255, 8'd203,
        8'd132, 8'd194, 8'd22, 8'd198, 8'd94, 8'd59, 8'd175, 8'd240,
        8'd246, 8'd118, 8'd123, 8'd106, 8'd10, 8'd48, 8'd122, 8'd0
    };

    // floor((2^32 - 1) / (2^n - 1)), indexed by n - 1
    localparam logic [31:0] RECIP [16] = '{
        32'hFFFF_FFFF, 32'h5555_5555, 32'h2492_4924, 32'h1111_1111,
        32'h0842_1084, 32'h0410_4104, 32'h0204_0810, 32'h0101_0101,
        32'h0080_4020, 32'h0040_1004, 32'h0020_0400, 32'h0010_0100,
        32'h0008_0040, 32'h0004_0010, 32'h0002_0004, 32'h0001_0001
    };

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

// File: rtl/value_noise_2d_octaves.sv
// Fractal 2D value noise, one point per transaction.
// Input channel: in_valid / in_ready with coord_x, coord_y in unsigned Q16.16.
// Output channel: out_valid / out_ready with noise_level in unsigned Q8.8.
// Configuration: cfg_write with cfg_index and cfg_data writes frequency (0),
// octave_count (1) or seed_offset (2); write only while the pipeline is empty.
// Registers on the way: input, lane s2 to s5, adder chain, scale product, output.
// Throughput: one point per cycle unless the output stalls; every octave has its
// own lane of hash, smoothstep and blend stages, and the octave sum runs through a
// chain of MAX_OCTAVES adder stages, so nothing is shared between points.
// Each stage holds a valid bit and moves when the next stage is empty or moving,
// so bubbles are squeezed out and input is taken while a result waits.
// When the receiver stalls, the output register holds noise_level and the
// pipeline fills up; in_ready drops only when every stage is occupied.
// Reset clears all valid bits and loads frequency 1.0, four octaves and
// seed 254; in_ready is high right after reset.
module value_noise_2d_octaves
    import vn2d_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] noise_level,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int P_W   = FRAC_BITS + 8;
    localparam int SHIFT = 24 - FRAC_BITS;
    localparam int ACC_W = FRAC_BITS + 8 + MAX_OCTAVES;
    localparam int HI_W  = (ACC_W > 32) ? ACC_W - 32 : 1;
    localparam int Q_W   = HI_W + 33;
    localparam int N_W   = $clog2(MAX_OCTAVES + 1);

    logic [15:0] frequency_reg;
    logic [3:0]  octave_count_reg;
    logic [7:0]  seed_offset_reg;

    logic [N_W-1:0] oct_n;

    logic        en1;
    logic        en_n1;
    logic        en_n2;
    stage_en_t   lane_en;
    logic [MAX_OCTAVES-1:0] hen;

    logic [47:0]    prod_x;
    logic [47:0]    prod_y;
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;
    logic           v4_reg;
    logic           v5_reg;
    logic [P_W-1:0] px1_reg;
    logic [P_W-1:0] py1_reg;

    logic [P_W-1:0] lane_col [MAX_OCTAVES];

    logic [MAX_OCTAVES-1:0] hv_reg;
    logic [ACC_W-1:0]       hacc_reg [MAX_OCTAVES];
    logic [P_W-1:0]         hcol_reg [MAX_OCTAVES][MAX_OCTAVES];

    logic [ACC_W-1:0] acc;
    logic [HI_W-1:0]  acc_hi;
    logic [31:0]      acc_lo;
    logic [31:0]      recip;
    logic [63:0]      pl_full;
    logic             n1v_reg;
    logic [HI_W+31:0] ph_reg;
    logic [31:0]      pl_reg;
    logic [Q_W-1:0]   q;
    logic             ov_reg;
    logic [15:0]      noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frequency_reg    <= FREQUENCY_RESET;
            octave_count_reg <= OCTAVES_RESET;
            seed_offset_reg  <= SEED_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FREQUENCY: frequency_reg    <= cfg_data;
                CFG_OCTAVES:   octave_count_reg <= cfg_data[3:0];
                CFG_SEED:      seed_offset_reg  <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    assign oct_n = (octave_count_reg == 4'd0) ? N_W'(1) :
                   ((32'(octave_count_reg) > MAX_OCTAVES) ? N_W'(MAX_OCTAVES) :
                   N_W'(octave_count_reg));

    assign en_n2      = !ov_reg || out_ready;
    assign en_n1      = !n1v_reg || en_n2;
    assign lane_en.s5 = !v5_reg || hen[0];
    assign lane_en.s4 = !v4_reg || lane_en.s5;
    assign lane_en.s3 = !v3_reg || lane_en.s4;
    assign lane_en.s2 = !v2_reg || lane_en.s3;
    assign en1        = !v1_reg || lane_en.s2;
    assign in_ready   = en1;

    assign prod_x = 48'(coord_x) * 48'(frequency_reg);
    assign prod_y = 48'(coord_y) * 48'(frequency_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (lane_en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (lane_en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (lane_en.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (lane_en.s5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            px1_reg <= P_W'(prod_x >> SHIFT);
            py1_reg <= P_W'(prod_y >> SHIFT);
        end
    end

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_lane
        logic [P_W-1:0] lane_px;
        logic [P_W-1:0] lane_py;

        assign lane_px = P_W'(px1_reg << i);
        assign lane_py = P_W'(py1_reg << i);

        vn2d_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk         (clk),
            .en          (lane_en),
            .pos_x       (lane_px),
            .pos_y       (lane_py),
            .seed_offset (seed_offset_reg),
            .col         (lane_col[i])
        );
    end

    for (genvar j = 0; j < MAX_OCTAVES; j++)
    begin : g_sum
        logic             src_v;
        logic [ACC_W-1:0] src_acc;
        logic [P_W-1:0]   src_col [MAX_OCTAVES];
        logic [ACC_W-1:0] acc_next;

        if (j == 0)
        begin : g_head
            assign src_v   = v5_reg;
            assign src_acc = '0;
            assign src_col = lane_col;
        end
        else
        begin : g_body
            assign src_v   = hv_reg[j-1];
            assign src_acc = hacc_reg[j-1];
            assign src_col = hcol_reg[j-1];
        end

        if (j == MAX_OCTAVES - 1)
        begin : g_tail
            assign hen[j] = !hv_reg[j] || en_n1;
        end
        else
        begin : g_link
            assign hen[j] = !hv_reg[j] || hen[j+1];
        end

        assign acc_next = (j < oct_n) ? ACC_W'((src_acc << 1) + ACC_W'(src_col[j])) : src_acc;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hv_reg[j] <= 1'b0;
            end
            else if (hen[j])
            begin
                hv_reg[j] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (hen[j])
            begin
                hacc_reg[j] <= acc_next;
                hcol_reg[j] <= src_col;
            end
        end
    end

    assign acc     = hacc_reg[MAX_OCTAVES-1];
    assign acc_hi  = HI_W'(acc >> 32);
    assign acc_lo  = 32'(acc);
    assign recip   = RECIP[4'(oct_n - N_W'(1))];
    assign pl_full = 64'(acc_lo) * 64'(recip);
    assign q       = Q_W'(ph_reg) + Q_W'(pl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (en_n1)
            begin
                n1v_reg <= hv_reg[MAX_OCTAVES-1];
            end
            if (en_n2)
            begin
                ov_reg <= n1v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_n1)
        begin
            ph_reg <= (HI_W+32)'(acc_hi) * (HI_W+32)'(recip);
            pl_reg <= pl_full[63:32];
        end
        if (en_n2)
        begin
            noise_reg <= q[FRAC_BITS+7:FRAC_BITS-8];
        end
    end

    assign out_valid   = ov_reg;
    assign noise_level = noise_reg;

endmodule

// File: rtl/vn2d_lane.sv
module vn2d_lane
    import vn2d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  stage_en_t            en,
    input  logic [FRAC_BITS+7:0] pos_x,
    input  logic [FRAC_BITS+7:0] pos_y,
    input  logic [7:0]           seed_offset,
    output logic [FRAC_BITS+7:0] col
);

    localparam int F   = FRAC_BITS;
    localparam int W_W = F + 1;
    localparam int K_W = F + 2;
    localparam int M_W = F + 9;

    logic [F-1:0]     sx;
    logic [F-1:0]     sy;
    logic [7:0]       ix;
    logic [7:0]       iy;
    logic [2*F-1:0]   sqx_full;
    logic [2*F-1:0]   sqy_full;
    logic [K_W-1:0]   kx;
    logic [K_W-1:0]   ky;
    logic [7:0]       ya;
    logic [7:0]       yb;

    logic [F-1:0]     sqx_reg;
    logic [F-1:0]     sqy_reg;
    logic [K_W-1:0]   kx_reg;
    logic [K_W-1:0]   ky_reg;
    logic [7:0]       ix2_reg;
    logic [7:0]       rowa_reg;
    logic [7:0]       rowb_reg;

    logic [2*F+1:0]   wx_full;
    logic [2*F+1:0]   wy_full;
    logic [7:0]       idx_a0;
    logic [7:0]       idx_a1;
    logic [7:0]       idx_b0;
    logic [7:0]       idx_b1;

    logic [W_W-1:0]   wx3_reg;
    logic [W_W-1:0]   wy3_reg;
    logic [7:0]       h00_reg;
    logic [7:0]       h10_reg;
    logic [7:0]       h01_reg;
    logic [7:0]       h11_reg;

    logic [W_W-1:0]   wxc;
    logic [M_W-1:0]   lo_full;
    logic [M_W-1:0]   hi_full;

    logic [7:0]       lo4_reg;
    logic [7:0]       hi4_reg;
    logic [W_W-1:0]   wy4_reg;

    logic [W_W-1:0]   wyc;
    logic [M_W-1:0]   col_full;
    logic [F+7:0]     col_reg;

    assign sx = pos_x[F-1:0];
    assign sy = pos_y[F-1:0];
    assign ix = pos_x[F+7:F];
    assign iy = pos_y[F+7:F];

    assign sqx_full = (2*F)'(sx) * (2*F)'(sx);
    assign sqy_full = (2*F)'(sy) * (2*F)'(sy);
    assign kx = {2'b11, {F{1'b0}}} - {1'b0, sx, 1'b0};
    assign ky = {2'b11, {F{1'b0}}} - {1'b0, sy, 1'b0};
    assign ya = iy + seed_offset;
    assign yb = ya + 8'd1;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            sqx_reg  <= sqx_full[2*F-1:F];
            sqy_reg  <= sqy_full[2*F-1:F];
            kx_reg   <= kx;
            ky_reg   <= ky;
            ix2_reg  <= ix;
            rowa_reg <= PERM[ya];
            rowb_reg <= PERM[yb];
        end
    end

    assign wx_full = (2*F+2)'(sqx_reg) * (2*F+2)'(kx_reg);
    assign wy_full = (2*F+2)'(sqy_reg) * (2*F+2)'(ky_reg);
    assign idx_a0 = rowa_reg + ix2_reg;
    assign idx_a1 = idx_a0 + 8'd1;
    assign idx_b0 = rowb_reg + ix2_reg;
    assign idx_b1 = idx_b0 + 8'd1;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            wx3_reg <= wx_full[2*F:F];
            wy3_reg <= wy_full[2*F:F];
            h00_reg <= PERM[idx_a0];
            h10_reg <= PERM[idx_a1];
            h01_reg <= PERM[idx_b0];
            h11_reg <= PERM[idx_b1];
        end
    end

    assign wxc = {1'b1, {F{1'b0}}} - wx3_reg;
    assign lo_full = M_W'(h00_reg) * M_W'(wxc) + M_W'(h10_reg) * M_W'(wx3_reg);
    assign hi_full = M_W'(h01_reg) * M_W'(wxc) + M_W'(h11_reg) * M_W'(wx3_reg);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            lo4_reg <= lo_full[F+7:F];
            hi4_reg <= hi_full[F+7:F];
            wy4_reg <= wy3_reg;
        end
    end

    assign wyc = {1'b1, {F{1'b0}}} - wy4_reg;
    assign col_full = M_W'(lo4_reg) * M_W'(wyc) + M_W'(hi4_reg) * M_W'(wy4_reg);

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            col_reg <= col_full[F+7:0];
        end
    end

    assign col = col_reg;

endmodule

// File: rtl/vn2d_checker.sv
module vn2d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] noise_level
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise_level))
        else $error("stalled result changed or dropped");

    // drop in_ready only while a stalled result waits at the output
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused while pipeline has room");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid && in_ready)
        else $error("pipeline not empty during reset");

endmodule

bind value_noise_2d_octaves vn2d_checker u_vn2d_checker (.*);
